// File: src/clt_pkg.sv
// Shared types, constants and scan helpers for the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

  // Limits of the tokenizer.
  localparam int MAX_ARGS   = 16;
  localparam int MAX_STAGES = 6;
  localparam int LINE_LEN   = 512;

  // Results one character can cause, and the depth of the group queue.
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // Scanner modes.
  typedef enum logic [2:0] {
    MD_BETWEEN,
    MD_ARG,
    MD_GT,
    MD_PSKIP,
    MD_PATH,
    MD_IGN_STAGE,
    MD_IGN_LINE
  } mode_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_ARG,
    EV_STDIN,
    EV_STDOUT,
    EV_STAGE,
    EV_LINE
  } ev_t;

  // One result item without its last mark.
  typedef struct packed {
    ev_t        ev;
    logic [2:0] stage;
    logic [3:0] arg_index;
    logic [8:0] start;
    logic [8:0] length;
    logic [4:0] argc;
    logic       merge;
    logic [2:0] stage_count;
  } event_t;

  // All results caused by one character.
  typedef struct packed {
    event_t [MAX_RES-1:0] slot;
    logic [1:0]           cnt;
  } group_t;

  // Scanner state.
  typedef struct packed {
    mode_t      mode;
    ev_t        kind;
    logic [8:0] tstart;
    logic [1:0] mp;
    logic [4:0] ac;
    logic [2:0] si;
    logic       mf;
  } scan_t;

  // State after a token is closed, and the event it gives if any.
  typedef struct packed {
    scan_t  s;
    logic   emit;
    event_t ev;
  } fin_t;

  localparam scan_t SCAN_RESET = '{
    mode:   MD_BETWEEN,
    kind:   EV_ARG,
    tstart: 9'd0,
    mp:     2'd0,
    ac:     5'd0,
    si:     3'd0,
    mf:     1'b0
  };

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic event_t mk_event(ev_t ev, logic [2:0] stg, logic [3:0] ai,
                                      logic [8:0] st, logic [8:0] len,
                                      logic [4:0] ac, logic mf, logic [2:0] cnt);
    event_t e;
    e.ev          = ev;
    e.stage       = stg;
    e.arg_index   = ai;
    e.start       = st;
    e.length      = len;
    e.argc        = ac;
    e.merge       = mf;
    e.stage_count = cnt;
    return e;
  endfunction

  // Close the pending token at offset pos_end.
  function automatic fin_t finish_token(scan_t s, logic [8:0] pos_end);
    fin_t r;
    r.s    = s;
    r.emit = 1'b0;
    r.ev   = '0;
    case (s.mode)
      MD_ARG: begin
        if (s.ac >= 5'(MAX_ARGS)) begin
          r.s.mode = MD_IGN_STAGE;
        end else begin
          r.emit   = 1'b1;
          r.ev     = mk_event(EV_ARG, s.si, s.ac[3:0], s.tstart, pos_end - s.tstart,
                              5'd0, 1'b0, 3'd0);
          r.s.ac   = s.ac + 5'd1;
          r.s.mode = MD_BETWEEN;
        end
        r.s.mp = 2'd0;
      end
      MD_GT, MD_PSKIP: begin
        r.emit   = 1'b1;
        r.ev     = mk_event(s.kind, s.si, 4'd0, pos_end, 9'd0, 5'd0, 1'b0, 3'd0);
        r.s.mode = MD_BETWEEN;
      end
      MD_PATH: begin
        r.emit   = 1'b1;
        r.ev     = mk_event(s.kind, s.si, 4'd0, s.tstart, pos_end - s.tstart,
                            5'd0, 1'b0, 3'd0);
        r.s.mode = MD_BETWEEN;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/command_line_tokenizer_unit.sv
// Top level of the command line tokenizer: front part, group queue and back part.
// Throughput: one character item per cycle while full is low; result items leave at one per cycle while pop is high.
// The results of an accepted character are written into the group queue, then loaded into the back part to be shown.
// A character can cause up to three results; full rises when four groups wait.
// Reset is synchronous and clears scanner state, queue pointers and the output stage's valid flag and index.
`timescale 1ns / 1ps

module command_line_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_res,
  output logic [2:0] stage,
  output logic [3:0] arg_index,
  output logic [8:0] start_res,
  output logic [8:0] length,
  output logic [4:0] argc,
  output logic       merge_err,
  output logic [2:0] stage_count,
  output logic       last
);

  logic            wr;
  clt_pkg::group_t wr_group;
  logic            q_rd;
  logic            q_valid;
  clt_pkg::group_t q_group;

  // Character scanner.
  clt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .ch          (ch),
    .end_of_line (end_of_line),
    .wr          (wr),
    .wr_group    (wr_group)
  );

  // Decoupling queue.
  clt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_group (wr_group),
    .rd       (q_rd),
    .full     (full),
    .rd_valid (q_valid),
    .rd_group (q_group)
  );

  // Result output stage.
  clt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_group     (q_group),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .event_res   (event_res),
    .stage       (stage),
    .arg_index   (arg_index),
    .start_res   (start_res),
    .length      (length),
    .argc        (argc),
    .merge_err   (merge_err),
    .stage_count (stage_count),
    .last        (last)
  );

endmodule

// File: src/clt_front.sv
// Front part: accepts characters, updates the scanner and builds result groups.
`timescale 1ns / 1ps

module clt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  logic [7:0]          ch,
  input  logic                end_of_line,
  output logic                wr,
  output clt_pkg::group_t     wr_group
);

  clt_pkg::scan_t  scan;
  clt_pkg::scan_t  scan_next;
  logic [8:0]      position;
  logic [8:0]      position_next;
  logic            accept;

  clt_pkg::scan_t  s;
  clt_pkg::fin_t   f;
  clt_pkg::group_t g;
  logic [1:0]      n;
  logic [8:0]      pos;
  logic [2:0]      l_stg;
  logic [4:0]      l_ac;
  logic            l_mf;

  assign accept = push && !full;

  // Work out the effect of one character: new state and up to three results.
  always_comb begin
    s     = scan;
    pos   = position;
    g     = '0;
    n     = 2'd0;
    f     = '0;
    l_stg = 3'd0;
    l_ac  = 5'd0;
    l_mf  = 1'b0;

    if (s.mode != clt_pkg::MD_IGN_LINE) begin
      if (ch == clt_pkg::CH_NUL || pos >= 9'(clt_pkg::LINE_LEN - 1)) begin
        // A zero byte or an overlong line ends the line content.
        f = clt_pkg::finish_token(s, pos);
        s = f.s;
        if (f.emit) begin
          g.slot[n] = f.ev;
          n = n + 2'd1;
        end
        s.mode = clt_pkg::MD_IGN_LINE;
      end else begin
        if (ch == clt_pkg::CH_PIPE) begin
          // A pipe closes the token and then the stage.
          f = clt_pkg::finish_token(s, pos);
          s = f.s;
          if (f.emit) begin
            g.slot[n] = f.ev;
            n = n + 2'd1;
          end
          if (s.si < 3'(clt_pkg::MAX_STAGES)) begin
            g.slot[n] = clt_pkg::mk_event(clt_pkg::EV_STAGE, s.si, 4'd0, 9'd0, 9'd0,
                                          s.ac, s.mf, 3'd0);
            n = n + 2'd1;
            if (s.ac != 5'd0) begin
              s.si = s.si + 3'd1;
            end
          end
          s.ac   = 5'd0;
          s.mf   = 1'b0;
          s.mp   = 2'd0;
          s.mode = (s.si >= 3'(clt_pkg::MAX_STAGES)) ? clt_pkg::MD_IGN_STAGE
                                                      : clt_pkg::MD_BETWEEN;
        end else begin
          case (s.mode)
            clt_pkg::MD_BETWEEN: begin
              if (clt_pkg::is_blank(ch)) begin
                s.mode = clt_pkg::MD_BETWEEN;
              end else if (ch == clt_pkg::CH_NL) begin
                s.mode = clt_pkg::MD_IGN_STAGE;
              end else if (ch == clt_pkg::CH_GT) begin
                s.mode = clt_pkg::MD_GT;
                s.kind = clt_pkg::EV_STDOUT;
              end else if (ch == clt_pkg::CH_LT) begin
                s.mode = clt_pkg::MD_PSKIP;
                s.kind = clt_pkg::EV_STDIN;
              end else begin
                s.mode   = clt_pkg::MD_ARG;
                s.kind   = clt_pkg::EV_ARG;
                s.tstart = pos;
                s.mp     = (ch == clt_pkg::CH_TWO) ? 2'd1 : 2'd0;
              end
            end
            clt_pkg::MD_ARG: begin
              if (clt_pkg::is_blank(ch) || ch == clt_pkg::CH_NL) begin
                f = clt_pkg::finish_token(s, pos);
                s = f.s;
                if (f.emit) begin
                  g.slot[n] = f.ev;
                  n = n + 2'd1;
                end
              end else if (s.mp == 2'd3 && ch == clt_pkg::CH_ONE) begin
                // A complete stderr merge mark ends here.
                s.mf   = 1'b1;
                s.mp   = 2'd0;
                s.mode = clt_pkg::MD_BETWEEN;
              end else if ((s.mp == 2'd1 && ch == clt_pkg::CH_GT) ||
                           (s.mp == 2'd2 && ch == clt_pkg::CH_AMP)) begin
                s.mp = s.mp + 2'd1;
              end else begin
                s.mp = 2'd0;
              end
            end
            clt_pkg::MD_GT: begin
              if (ch == clt_pkg::CH_GT || clt_pkg::is_blank(ch)) begin
                s.mode = clt_pkg::MD_PSKIP;
              end else if (ch == clt_pkg::CH_NL) begin
                f = clt_pkg::finish_token(s, pos);
                s = f.s;
                if (f.emit) begin
                  g.slot[n] = f.ev;
                  n = n + 2'd1;
                end
              end else begin
                s.mode   = clt_pkg::MD_PATH;
                s.tstart = pos;
              end
            end
            clt_pkg::MD_PSKIP: begin
              if (clt_pkg::is_blank(ch)) begin
                s.mode = clt_pkg::MD_PSKIP;
              end else if (ch == clt_pkg::CH_NL) begin
                f = clt_pkg::finish_token(s, pos);
                s = f.s;
                if (f.emit) begin
                  g.slot[n] = f.ev;
                  n = n + 2'd1;
                end
              end else begin
                s.mode   = clt_pkg::MD_PATH;
                s.tstart = pos;
              end
            end
            clt_pkg::MD_PATH: begin
              if (clt_pkg::is_blank(ch) || ch == clt_pkg::CH_NL) begin
                f = clt_pkg::finish_token(s, pos);
                s = f.s;
                if (f.emit) begin
                  g.slot[n] = f.ev;
                  n = n + 2'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        pos = pos + 9'd1;
      end
    end

    // The final character closes the token, reports the last stage and clears state.
    if (end_of_line) begin
      if (s.mode != clt_pkg::MD_IGN_LINE) begin
        f = clt_pkg::finish_token(s, pos);
        s = f.s;
        if (f.emit) begin
          g.slot[n] = f.ev;
          n = n + 2'd1;
        end
      end
      if (s.si < 3'(clt_pkg::MAX_STAGES)) begin
        l_stg = s.si;
        l_ac  = s.ac;
        l_mf  = s.mf;
        if (s.ac != 5'd0) begin
          s.si = s.si + 3'd1;
        end
      end
      g.slot[n] = clt_pkg::mk_event(clt_pkg::EV_LINE, l_stg, 4'd0, 9'd0, 9'd0,
                                    l_ac, l_mf, s.si);
      n = n + 2'd1;
      s   = clt_pkg::SCAN_RESET;
      pos = 9'd0;
    end

    g.cnt         = n;
    scan_next     = s;
    position_next = pos;
    wr_group      = g;
    wr            = accept && (n != 2'd0);
  end

  // Scanner state advances on every accepted character.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan     <= clt_pkg::SCAN_RESET;
      position <= 9'd0;
    end else if (accept) begin
      scan     <= scan_next;
      position <= position_next;
    end
  end

endmodule

// File: src/clt_queue.sv
// Short queue of result groups between the front and back parts.
`timescale 1ns / 1ps

module clt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  clt_pkg::group_t wr_group,
  input  logic            rd,
  output logic            full,
  output logic            rd_valid,
  output clt_pkg::group_t rd_group
);

  clt_pkg::group_t          mem [clt_pkg::Q_DEPTH];
  logic [clt_pkg::Q_AW-1:0] wr_ptr;
  logic [clt_pkg::Q_AW-1:0] rd_ptr;
  logic [clt_pkg::Q_AW:0]   count;
  logic                     do_wr;
  logic                     do_rd;

  assign full     = (count == (clt_pkg::Q_AW + 1)'(clt_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_group = mem[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  // Storage for waiting groups.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_group;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + (clt_pkg::Q_AW)'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + (clt_pkg::Q_AW)'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (clt_pkg::Q_AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (clt_pkg::Q_AW + 1)'(1);
      end
    end
  end

endmodule

// File: src/clt_back.sv
// Back part: holds one result group and hands out its items one at a time.
`timescale 1ns / 1ps

module clt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  clt_pkg::group_t q_group,
  output logic            q_rd,
  input  logic            pop,
  output logic            empty,
  output logic [2:0]      event_res,
  output logic [2:0]      stage,
  output logic [3:0]      arg_index,
  output logic [8:0]      start_res,
  output logic [8:0]      length,
  output logic [4:0]      argc,
  output logic            merge_err,
  output logic [2:0]      stage_count,
  output logic            last
);

  clt_pkg::group_t cur;
  logic [1:0]      idx;
  logic            cur_valid;
  clt_pkg::event_t ev;
  logic            advance;
  logic            done;

  assign ev      = cur.slot[idx];
  assign last    = (idx == cur.cnt - 2'd1);
  assign empty   = !cur_valid;
  assign advance = pop && cur_valid;
  assign done    = advance && last;
  assign q_rd    = q_valid && (!cur_valid || done);

  // Result fields of the item on display.
  assign event_res   = ev.ev;
  assign stage       = ev.stage;
  assign arg_index   = ev.arg_index;
  assign start_res   = ev.start;
  assign length      = ev.length;
  assign argc        = ev.argc;
  assign merge_err   = ev.merge;
  assign stage_count = ev.stage_count;

  // Group payload is loaded whenever a new group is taken from the queue.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_group;
    end
  end

  // Item index within the group and the valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (advance) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// File: sim/command_line_tokenizer_unit_test.sv
// Self-checking testbench for the command line tokenizer unit.
`timescale 1ns / 1ps

module command_line_tokenizer_unit_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int TARGET_ITEMS   = 380;

  // One result item as the tokenizer should report it.
  typedef struct {
    clt_pkg::ev_t ev;
    logic [2:0]   stage;
    logic [3:0]   arg_index;
    logic [8:0]   start_res;
    logic [8:0]   length;
    logic [4:0]   argc;
    logic         merge_err;
    logic [2:0]   stage_count;
    logic         last;
  } token_event_t;

  // One character item waiting to be sent.
  typedef struct {
    logic [7:0] c;
    logic       eol;
    bit         drain;
  } char_item_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] ch = 8'h00;
  logic       end_of_line = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] event_res;
  logic [2:0] stage;
  logic [3:0] arg_index;
  logic [8:0] start_res;
  logic [8:0] length;
  logic [4:0] argc;
  logic       merge_err;
  logic [2:0] stage_count;
  logic       last;

  // Tokenizer state kept by the predictor.
  clt_pkg::mode_t tk_mode;
  clt_pkg::ev_t   tk_kind;
  int             tk_start;
  int             tk_pos;
  int             tk_merge;
  int             tk_args;
  int             tk_stage;
  bit             tk_mflag;

  token_event_t step_events[$];
  token_event_t expected_events[$];
  char_item_t   pending_chars[$];
  logic [7:0]   line_chars[$];

  // Handshake bookkeeping shared between the driver, monitor and predictor.
  logic       took_valid = 1'b0;
  logic [7:0] took_ch = 8'h00;
  logic       took_eol = 1'b0;
  int         n_predicted = 0;
  int         n_checked = 0;
  int         n_sent = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         wait_n;
  int         idle_cycles = 0;
  int         errors = 0;
  bit         long_hold = 1'b0;
  bit         long_done = 1'b0;
  char_item_t next_char;

  command_line_tokenizer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .ch(ch),
    .end_of_line(end_of_line),
    .empty(empty),
    .pop(pop),
    .event_res(event_res),
    .stage(stage),
    .arg_index(arg_index),
    .start_res(start_res),
    .length(length),
    .argc(argc),
    .merge_err(merge_err),
    .stage_count(stage_count),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit is_gap(logic [7:0] c);
    return c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB;
  endfunction

  task automatic clear_scanner();
    tk_mode  = clt_pkg::MD_BETWEEN;
    tk_kind  = clt_pkg::EV_ARG;
    tk_start = 0;
    tk_pos   = 0;
    tk_merge = 0;
    tk_args  = 0;
    tk_stage = 0;
    tk_mflag = 1'b0;
  endtask

  // At most three events leave per character; anything beyond is lost.
  task automatic note_event(clt_pkg::ev_t ev, int stg, int ai, int st, int len, int ac,
                            bit mf, int cnt);
    token_event_t e;
    if (step_events.size() < clt_pkg::MAX_RES) begin
      e.ev          = ev;
      e.stage       = 3'(stg);
      e.arg_index   = 4'(ai);
      e.start_res   = 9'(st);
      e.length      = 9'(len);
      e.argc        = 5'(ac);
      e.merge_err   = mf;
      e.stage_count = 3'(cnt);
      e.last        = 1'b0;
      step_events.push_back(e);
    end
  endtask

  // Close whatever token is open, ending it at offset end_pos.
  task automatic close_token(int end_pos);
    case (tk_mode)
      clt_pkg::MD_ARG: begin
        if (tk_args >= clt_pkg::MAX_ARGS) begin
          tk_mode = clt_pkg::MD_IGN_STAGE;
        end else begin
          note_event(clt_pkg::EV_ARG, tk_stage, tk_args, tk_start, end_pos - tk_start,
                     0, 1'b0, 0);
          tk_args++;
          tk_mode = clt_pkg::MD_BETWEEN;
        end
        tk_merge = 0;
      end
      clt_pkg::MD_GT, clt_pkg::MD_PSKIP: begin
        note_event(tk_kind, tk_stage, 0, end_pos, 0, 0, 1'b0, 0);
        tk_mode = clt_pkg::MD_BETWEEN;
      end
      clt_pkg::MD_PATH: begin
        note_event(tk_kind, tk_stage, 0, tk_start, end_pos - tk_start, 0, 1'b0, 0);
        tk_mode = clt_pkg::MD_BETWEEN;
      end
      default: ;
    endcase
  endtask

  // A stage end is reported only while the stage index is in range.
  task automatic close_stage();
    if (tk_stage < clt_pkg::MAX_STAGES) begin
      note_event(clt_pkg::EV_STAGE, tk_stage, 0, 0, 0, tk_args, tk_mflag, 0);
      if (tk_args > 0) tk_stage++;
    end
    tk_args  = 0;
    tk_mflag = 1'b0;
    tk_merge = 0;
    tk_mode  = (tk_stage >= clt_pkg::MAX_STAGES) ? clt_pkg::MD_IGN_STAGE
                                                 : clt_pkg::MD_BETWEEN;
  endtask

  task automatic scan_char(logic [7:0] c, int pos);
    if (c == clt_pkg::CH_PIPE) begin
      close_token(pos);
      close_stage();
    end else begin
      case (tk_mode)
        clt_pkg::MD_BETWEEN: begin
          if (c == clt_pkg::CH_NL) begin
            tk_mode = clt_pkg::MD_IGN_STAGE;
          end else if (c == clt_pkg::CH_GT) begin
            tk_mode = clt_pkg::MD_GT;
            tk_kind = clt_pkg::EV_STDOUT;
          end else if (c == clt_pkg::CH_LT) begin
            tk_mode = clt_pkg::MD_PSKIP;
            tk_kind = clt_pkg::EV_STDIN;
          end else if (!is_gap(c)) begin
            tk_mode  = clt_pkg::MD_ARG;
            tk_kind  = clt_pkg::EV_ARG;
            tk_start = pos;
            tk_merge = (c == clt_pkg::CH_TWO) ? 1 : 0;
          end
        end
        clt_pkg::MD_ARG: begin
          // Track the 2>&1 prefix; a complete mark is not an argument.
          if (is_gap(c) || c == clt_pkg::CH_NL) begin
            close_token(pos);
          end else if (tk_merge == 3 && c == clt_pkg::CH_ONE) begin
            tk_mflag = 1'b1;
            tk_merge = 0;
            tk_mode  = clt_pkg::MD_BETWEEN;
          end else if ((tk_merge == 1 && c == clt_pkg::CH_GT) ||
                       (tk_merge == 2 && c == clt_pkg::CH_AMP)) begin
            tk_merge++;
          end else begin
            tk_merge = 0;
          end
        end
        clt_pkg::MD_GT: begin
          if (c == clt_pkg::CH_GT || is_gap(c)) begin
            tk_mode = clt_pkg::MD_PSKIP;
          end else if (c == clt_pkg::CH_NL) begin
            close_token(pos);
          end else begin
            tk_mode  = clt_pkg::MD_PATH;
            tk_start = pos;
          end
        end
        clt_pkg::MD_PSKIP: begin
          if (c == clt_pkg::CH_NL) begin
            close_token(pos);
          end else if (!is_gap(c)) begin
            tk_mode  = clt_pkg::MD_PATH;
            tk_start = pos;
          end
        end
        clt_pkg::MD_PATH: begin
          if (is_gap(c) || c == clt_pkg::CH_NL) close_token(pos);
        end
        default: ;
      endcase
    end
  endtask

  // Work out every event one accepted character causes and queue them.
  task automatic tokenize_char(logic [7:0] c, logic eol);
    token_event_t e;
    int stg;
    int ac;
    bit mf;
    step_events.delete();
    if (tk_mode != clt_pkg::MD_IGN_LINE) begin
      // A zero byte or the last offset of the buffer ends the line content.
      if (c == clt_pkg::CH_NUL || tk_pos >= clt_pkg::LINE_LEN - 1) begin
        close_token(tk_pos);
        tk_mode = clt_pkg::MD_IGN_LINE;
      end else begin
        scan_char(c, tk_pos);
        tk_pos++;
      end
    end
    if (eol) begin
      if (tk_mode != clt_pkg::MD_IGN_LINE) close_token(tk_pos);
      stg = 0;
      ac  = 0;
      mf  = 1'b0;
      if (tk_stage < clt_pkg::MAX_STAGES) begin
        stg = tk_stage;
        ac  = tk_args;
        mf  = tk_mflag;
        if (ac > 0) tk_stage++;
      end
      note_event(clt_pkg::EV_LINE, stg, 0, 0, 0, ac, mf, tk_stage);
      clear_scanner();
    end
    if (step_events.size() > 0) begin
      e = step_events.pop_back();
      e.last = 1'b1;
      step_events.push_back(e);
    end
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
    n_predicted += step_events.size();
  endtask

  // Line building for the stimulus.
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endtask

  task automatic put_blanks(int n);
    for (int i = 0; i < n; i++) begin
      line_chars.push_back($urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB);
    end
  endtask

  task automatic put_word();
    string odd;
    int n;
    int r;
    logic [7:0] c;
    odd = "2&1><";
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 7);
      if (r <= 4) begin
        c = 8'h61 + 8'($urandom_range(0, 25));
      end else if (r == 5) begin
        c = odd[$urandom_range(0, 4)];
      end else if (r == 6) begin
        c = 8'($urandom_range(8'h21, 8'hFF));
        if (c == clt_pkg::CH_PIPE) c = 8'h7E;
      end else begin
        c = 8'h30 + 8'($urandom_range(0, 9));
      end
      line_chars.push_back(c);
    end
  endtask

  task automatic put_token();
    int r;
    int k;
    r = $urandom_range(0, 11);
    if (r <= 5) begin
      put_word();
    end else if (r == 6) begin
      line_chars.push_back(clt_pkg::CH_GT);
      if ($urandom_range(0, 1)) line_chars.push_back(clt_pkg::CH_GT);
      if ($urandom_range(0, 1)) put_blanks($urandom_range(1, 2));
      if ($urandom_range(0, 3) != 0) put_word();
    end else if (r == 7) begin
      line_chars.push_back(clt_pkg::CH_LT);
      if ($urandom_range(0, 1)) put_blanks($urandom_range(1, 2));
      if ($urandom_range(0, 3) != 0) put_word();
    end else if (r == 8) begin
      put_text("2>&1");
      if ($urandom_range(0, 2) == 0) put_word();
    end else if (r == 9) begin
      // A merge mark cut short after one, two or three characters.
      k = $urandom_range(0, 2);
      line_chars.push_back(clt_pkg::CH_TWO);
      if (k >= 1) line_chars.push_back(clt_pkg::CH_GT);
      if (k >= 2) line_chars.push_back(clt_pkg::CH_AMP);
      if ($urandom_range(0, 1)) put_word();
    end else if (r == 10) begin
      line_chars.push_back(clt_pkg::CH_NL);
    end else begin
      put_word();
      line_chars.push_back(clt_pkg::CH_NL);
    end
  endtask

  task automatic random_line();
    string specials;
    int n_stages;
    int n_tok;
    int n;
    int r;
    specials = " \t\n|><2&1";
    if ($urandom_range(0, 9) < 3) begin
      // Noise: raw bytes with a bias toward the characters the scanner knows.
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) line_chars.push_back(clt_pkg::CH_NUL);
        else if (r <= 9) line_chars.push_back(specials[r - 1]);
        else line_chars.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      // Well-formed pipeline, sometimes past the stage or argument limit.
      n_stages = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 3);
      for (int s = 0; s < n_stages; s++) begin
        if (s > 0) begin
          if ($urandom_range(0, 1)) put_blanks(1);
          line_chars.push_back(clt_pkg::CH_PIPE);
          if ($urandom_range(0, 1)) put_blanks(1);
        end
        n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        for (int t = 0; t < n_tok; t++) begin
          if (t > 0) put_blanks($urandom_range(1, 2));
          put_token();
        end
      end
      if ($urandom_range(0, 5) == 0) line_chars.push_back(clt_pkg::CH_PIPE);
      else if ($urandom_range(0, 5) == 0) put_blanks($urandom_range(1, 3));
      if ($urandom_range(0, 14) == 0) begin
        line_chars.push_back(clt_pkg::CH_NUL);
        put_word();
      end
    end
  endtask

  task automatic commit_line(bit drain_first);
    char_item_t it;
    if (line_chars.size() == 0) line_chars.push_back(8'h78);
    foreach (line_chars[i]) begin
      it.c     = line_chars[i];
      it.eol   = (i == line_chars.size() - 1);
      it.drain = drain_first && (i == 0);
      pending_chars.push_back(it);
    end
    line_chars.delete();
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    token_event_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: event_res expected none got %0d (stage %0d)", $time, event_res, stage);
      errors++;
    end else begin
      want = expected_events.pop_front();
      n_checked <= n_checked + 1;
      check_field("event_res", int'(event_res), int'(want.ev));
      check_field("stage", int'(stage), int'(want.stage));
      check_field("arg_index", int'(arg_index), int'(want.arg_index));
      check_field("start_res", int'(start_res), int'(want.start_res));
      check_field("length", int'(length), int'(want.length));
      check_field("argc", int'(argc), int'(want.argc));
      check_field("merge_err", int'(merge_err), int'(want.merge_err));
      check_field("stage_count", int'(stage_count), int'(want.stage_count));
      check_field("last", int'(last), int'(want.last));
    end
  endtask

  // Driver: present the next character item once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      push        <= 1'b0;
      ch          <= 8'h00;
      end_of_line <= 1'b0;
      took_valid  <= 1'b0;
      gap_left    <= 0;
    end else begin
      took_valid <= push && !full;
      if (push && !full) begin
        took_ch  <= ch;
        took_eol <= end_of_line;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          push     <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_chars.size() > 0 &&
                     (!pending_chars[0].drain ||
                      (!push && !took_valid && n_predicted == n_checked))) begin
          next_char   = pending_chars.pop_front();
          push        <= 1'b1;
          ch          <= next_char.c;
          end_of_line <= next_char.eol;
          gap_left    <= (long_hold || (n_sent / 60) % 3 == 2) ? 0 : $urandom_range(0, 9);
          n_sent++;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Predict between clock edges so the monitor never races the predictor.
  always @(negedge clk) begin
    if (!rst && took_valid) tokenize_char(took_ch, took_eol);
  end

  // Monitor: take result items with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      stall_left <= 0;
      long_hold  <= 1'b0;
      long_done  <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result();
        if (!long_done && n_checked >= 50) begin
          long_done  <= 1'b1;
          long_hold  <= 1'b1;
          stall_left <= LONG_HOLD;
          pop        <= 1'b0;
        end else begin
          wait_n = ((n_checked / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
          stall_left <= wait_n;
          pop        <= (wait_n == 0);
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop        <= (stall_left == 1);
        if (stall_left == 1) long_hold <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("command_line_tokenizer_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    clear_scanner();

    // Directed lines: redirects, merge mark, limits of the byte range.
    put_text("a>f|");
    commit_line(1'b0);
    put_text("2>&1 <");
    commit_line(1'b0);
    put_text("2>x");
    commit_line(1'b0);
    put_text(">>");
    line_chars.push_back(clt_pkg::CH_NUL);
    put_text("z");
    commit_line(1'b0);
    put_text("\n a");
    commit_line(1'b0);
    line_chars.push_back(8'hFF);
    put_text("\t");
    commit_line(1'b0);
    put_text("|");
    commit_line(1'b0);
    put_text("<\n");
    commit_line(1'b0);

    // Random lines, with one line that runs past the buffer length.
    for (int line_no = 1; pending_chars.size() < TARGET_ITEMS; line_no++) begin
      if (line_no == 40) begin
        put_text("a ");
        put_blanks($urandom_range(500, 508));
        for (int i = 0; i < 12; i++) line_chars.push_back(8'h61 + 8'($urandom_range(0, 25)));
        commit_line(1'b0);
      end
      random_line();
      commit_line(line_no % 15 == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait until everything is sent and every predicted result has arrived.
    do begin
      @(posedge clk);
      #1;
    end while (!(pending_chars.size() == 0 && !push && !took_valid &&
                 n_predicted == n_checked));
    repeat (10) @(posedge clk);

    if (errors == 0 && expected_events.size() == 0) begin
      $display("command_line_tokenizer_unit_test OK");
    end else begin
      $display("command_line_tokenizer_unit_test NOT OK");
    end
    $finish;
  end

endmodule
